@@ design/uwrap_pkg.sv @@
// Shared constants, types and controller/datapath signal groups for the word wrap core.
`timescale 1ns / 1ps
`default_nettype none

package uwrap_pkg;

   localparam int MAX_COLUMNS = 60;
   localparam int COL_W       = 6;
   localparam int BUF_DEPTH   = MAX_COLUMNS;
   localparam int BUF_AW      = 6;
   localparam int CHAR_W      = 32;
   localparam int LEN_W       = 3;
   localparam int SLOT_W      = CHAR_W + LEN_W;
   localparam int ADDR_W      = 3;

   localparam logic [7:0]       CHAR_NL   = 8'h0A;
   localparam logic [7:0]       CHAR_SP   = 8'h20;
   localparam logic [7:0]       CONT_MASK = 8'hC0;
   localparam logic [7:0]       CONT_TAG  = 8'h80;
   localparam logic [LEN_W-1:0] MAX_LEN   = 3'd4;

   localparam logic ADDR_COLUMNS = 1'b0;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_NL,
      EMIT_SEP,
      EMIT_SLOT,
      EMIT_TERM
   } emit_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_NL_BRK,
      ST_BRK,
      ST_BRK_OUT,
      ST_APPEND,
      ST_EOT,
      ST_CLOSE,
      ST_SEP,
      ST_RD,
      ST_OUT,
      ST_CLOSE_END,
      ST_TERM
   } state_type;

   typedef struct packed {
      logic     ready;
      logic     word_begin;
      logic     tail_append;
      logic     append;
      logic     idx_clear;
      logic     idx_inc;
      logic     slot_read;
      logic     brk_done;
      logic     close_clear;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic is_space;
      logic is_cont;
      logic in_word;
      logic long_mode;
      logic wc_ge_width;
      logic lc_nonzero;
      logic lc_ge_width;
      logic idx_last;
      logic out_free;
      logic eot;
   } status_type;

endpackage

`default_nettype wire

@@ design/uwrap_if.sv @@
// Valid/ready channel interfaces for text bytes in and wrapped characters out.
`timescale 1ns / 1ps
`default_nettype none

interface uwrap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface uwrap_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte0;
   logic [7:0] char_byte1;
   logic [7:0] char_byte2;
   logic [7:0] char_byte3;
   logic [2:0] char_len;
   logic       end_marker;

   modport source (output valid, output char_byte0, output char_byte1, output char_byte2,
                   output char_byte3, output char_len, output end_marker, input ready);
   modport sink   (input valid, input char_byte0, input char_byte1, input char_byte2,
                   input char_byte3, input char_len, input end_marker, output ready);
endinterface

`default_nettype wire

@@ design/uwrap_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module uwrap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ design/uwrap_ctrl.sv @@
// Controller state machine sequencing decode, word close, line breaks and emission.
`timescale 1ns / 1ps
`default_nettype none

module uwrap_ctrl import uwrap_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire status_type st,
   output cmd_type         cmd,
   output state_type       state
);

   state_type state_ff, state_in;
   logic      brk_close_ff, brk_close_in;
   logic      eot_phase_ff, eot_phase_in;

   assign state = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         brk_close_ff <= 1'b0;
         eot_phase_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         brk_close_ff <= brk_close_in;
         eot_phase_ff <= eot_phase_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      brk_close_in = brk_close_ff;
      eot_phase_in = eot_phase_ff;
      cmd          = '0;
      cmd.emit     = EMIT_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (st.req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (st.is_space) begin
               state_in = ST_CLOSE;
            end else if (st.is_cont) begin
               cmd.tail_append = 1'b1;
               state_in        = ST_EOT;
            end else if (!st.in_word) begin
               cmd.word_begin = 1'b1;
               state_in       = ST_APPEND;
            end else if (st.long_mode) begin
               cmd.idx_clear = 1'b1;
               brk_close_in  = 1'b0;
               state_in      = ST_BRK;
            end else if (st.wc_ge_width) begin
               cmd.idx_clear = 1'b1;
               brk_close_in  = 1'b0;
               state_in      = st.lc_nonzero ? ST_NL_BRK : ST_BRK;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_NL_BRK: begin
            if (st.out_free) begin
               cmd.emit = EMIT_NL;
               state_in = ST_BRK;
            end
         end
         ST_BRK: begin
            if (st.lc_ge_width) begin
               if (st.out_free) begin
                  cmd.emit = EMIT_NL;
               end
            end else begin
               cmd.slot_read = 1'b1;
               state_in      = ST_BRK_OUT;
            end
         end
         ST_BRK_OUT: begin
            if (st.out_free) begin
               cmd.emit = EMIT_SLOT;
               if (st.idx_last) begin
                  if (brk_close_ff) begin
                     state_in = ST_CLOSE_END;
                  end else begin
                     cmd.brk_done = 1'b1;
                     state_in     = ST_APPEND;
                  end
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_BRK;
               end
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_EOT;
         end
         ST_EOT: begin
            if (st.eot) begin
               eot_phase_in = 1'b1;
               state_in     = ST_CLOSE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CLOSE: begin
            cmd.idx_clear = 1'b1;
            if (!st.in_word) begin
               state_in = ST_CLOSE_END;
            end else if (st.long_mode) begin
               brk_close_in = 1'b1;
               state_in     = ST_BRK;
            end else if (st.lc_nonzero) begin
               state_in = ST_SEP;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_SEP: begin
            if (st.out_free) begin
               cmd.emit = EMIT_SEP;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.slot_read = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (st.out_free) begin
               cmd.emit = EMIT_SLOT;
               if (st.idx_last) begin
                  state_in = ST_CLOSE_END;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_RD;
               end
            end
         end
         ST_CLOSE_END: begin
            cmd.close_clear = 1'b1;
            state_in        = eot_phase_ff ? ST_TERM : ST_EOT;
         end
         ST_TERM: begin
            if (st.out_free) begin
               cmd.emit     = EMIT_TERM;
               eot_phase_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ design/uwrap_dp.sv @@
// Datapath: input capture, word buffer, tail character, counters and output register.
`timescale 1ns / 1ps
`default_nettype none

module uwrap_dp import uwrap_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [COL_W-1:0] columns,
   input  wire cmd_type          cmd,
   output status_type            st,
   uwrap_req_if.sink             req,
   uwrap_rsp_if.source           rsp
);

   logic [7:0]        byte_ff;
   logic              eot_ff;
   logic [CHAR_W-1:0] tail_char_ff;
   logic [LEN_W-1:0]  tail_len_ff;
   logic [COL_W-1:0]  wc_ff, wc_in;
   logic [COL_W-1:0]  lc_ff, lc_in;
   logic [COL_W-1:0]  width_ff, width_in;
   logic [BUF_AW-1:0] idx_ff, idx_in;
   logic              long_ff, long_in;
   logic              inside_ff, inside_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_end_ff, rsp_end_in;

   logic [SLOT_W-1:0] ram_rd;
   logic [SLOT_W-1:0] slot;
   logic              idx_last;
   logic              sep_fits;
   logic              accept;

   assign accept   = cmd.ready & req.valid;
   assign req.ready = cmd.ready;
   assign idx_last = ({1'b0, idx_ff} + 7'd1) == {1'b0, wc_ff};
   assign sep_fits = ({1'b0, lc_ff} + 7'd1 + {1'b0, wc_ff}) <= {1'b0, width_ff};
   assign slot     = idx_last ? {tail_len_ff, tail_char_ff} : ram_rd;

   uwrap_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (BUF_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (cmd.append && (wc_ff != '0)),
      .wr_addr (wc_ff - 6'd1),
      .wr_data ({tail_len_ff, tail_char_ff}),
      .rd_en   (cmd.slot_read),
      .rd_addr (idx_ff),
      .rd_data (ram_rd)
   );

   always_comb begin
      st.req_valid   = req.valid;
      st.is_space    = byte_ff == CHAR_SP;
      st.is_cont     = inside_ff && (wc_ff != '0) && ((byte_ff & CONT_MASK) == CONT_TAG);
      st.in_word     = inside_ff;
      st.long_mode   = long_ff;
      st.wc_ge_width = wc_ff >= width_ff;
      st.lc_nonzero  = lc_ff != '0;
      st.lc_ge_width = lc_ff >= width_ff;
      st.idx_last    = idx_last;
      st.out_free    = !rsp_valid_ff || rsp.ready;
      st.eot         = eot_ff;
   end

   // word state
   always_comb begin
      wc_in     = wc_ff;
      width_in  = width_ff;
      long_in   = long_ff;
      inside_in = inside_ff;
      idx_in    = idx_ff;
      if (cmd.word_begin) begin
         inside_in = 1'b1;
         long_in   = 1'b0;
         wc_in     = '0;
         width_in  = columns;
      end
      if (cmd.append) begin
         wc_in = wc_ff + 6'd1;
      end
      if (cmd.brk_done) begin
         long_in = 1'b1;
         wc_in   = '0;
      end
      if (cmd.close_clear) begin
         inside_in = 1'b0;
         long_in   = 1'b0;
         wc_in     = '0;
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 6'd1;
      end
   end

   // output beat and line column
   always_comb begin
      lc_in        = lc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_end_in   = rsp_end_ff;
      case (cmd.emit)
         EMIT_NL: begin
            rsp_char_in = {24'b0, CHAR_NL};
            rsp_len_in  = 3'd1;
            rsp_end_in  = 1'b0;
            lc_in       = '0;
         end
         EMIT_SEP: begin
            rsp_char_in = {24'b0, (sep_fits ? CHAR_SP : CHAR_NL)};
            rsp_len_in  = 3'd1;
            rsp_end_in  = 1'b0;
            lc_in       = sep_fits ? lc_ff + 6'd1 : '0;
         end
         EMIT_SLOT: begin
            rsp_char_in = slot[CHAR_W-1:0];
            rsp_len_in  = slot[SLOT_W-1:CHAR_W];
            rsp_end_in  = 1'b0;
            lc_in       = (lc_ff < COL_W'(MAX_COLUMNS)) ? lc_ff + 6'd1 : lc_ff;
         end
         EMIT_TERM: begin
            rsp_char_in = '0;
            rsp_len_in  = '0;
            rsp_end_in  = 1'b1;
            lc_in       = '0;
         end
         default: begin
            lc_in = lc_ff;
         end
      endcase
      if (cmd.emit != EMIT_NONE) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff        <= '0;
         lc_ff        <= '0;
         width_ff     <= '0;
         idx_ff       <= '0;
         long_ff      <= 1'b0;
         inside_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wc_ff        <= wc_in;
         lc_ff        <= lc_in;
         width_ff     <= width_in;
         idx_ff       <= idx_in;
         long_ff      <= long_in;
         inside_ff    <= inside_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req.text_byte;
         eot_ff  <= req.end_of_text;
      end
      if (cmd.append) begin
         tail_char_ff <= {24'b0, byte_ff};
         tail_len_ff  <= 3'd1;
      end else if (cmd.tail_append && (tail_len_ff < MAX_LEN)) begin
         tail_char_ff[8*tail_len_ff[1:0] +: 8] <= byte_ff;
         tail_len_ff                          <= tail_len_ff + 3'd1;
      end
      rsp_char_ff <= rsp_char_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.char_byte0 = rsp_char_ff[7:0];
   assign rsp.char_byte1 = rsp_char_ff[15:8];
   assign rsp.char_byte2 = rsp_char_ff[23:16];
   assign rsp.char_byte3 = rsp_char_ff[31:24];
   assign rsp.char_len   = rsp_len_ff;
   assign rsp.end_marker = rsp_end_ff;

endmodule

`default_nettype wire

@@ design/utf8_greedy_word_wrap_core.sv @@
// Top level: UTF-8 greedy word wrap core with column register and controller/datapath.
// Ready drops when a byte is accepted and returns once that byte is handled, after any separator,
// newline or characters that it causes to be emitted. End of text adds its word close and the
// terminator, and an output stall holds ready low.
// Throughput: one byte in flight at a time. Synchronous active-high reset clears control
// state and sets columns to 60; the word buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module utf8_greedy_word_wrap_core import uwrap_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   uwrap_req_if.sink              req_chan,
   uwrap_rsp_if.source            rsp_chan,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   logic [COL_W-1:0] columns_ff, columns_in;
   logic [COL_W-1:0] wr_val;
   logic             csr_wr;
   cmd_type          cmd;
   status_type       st;
   state_type        state;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == ADDR_COLUMNS);
   assign wr_val = pwdata[COL_W-1:0];

   always_comb begin
      columns_in = columns_ff;
      if (csr_wr) begin
         if (wr_val == '0) begin
            columns_in = 6'd1;
         end else if (wr_val > COL_W'(MAX_COLUMNS)) begin
            columns_in = COL_W'(MAX_COLUMNS);
         end else begin
            columns_in = wr_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COL_W'(MAX_COLUMNS);
      end else begin
         columns_ff <= columns_in;
      end
   end

   assign prdata = (paddr[2] == ADDR_COLUMNS) ? {26'b0, columns_ff} : 32'b0;

   uwrap_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd),
      .state (state)
   );

   uwrap_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .columns (columns_ff),
      .cmd     (cmd),
      .st      (st),
      .req     (req_chan),
      .rsp     (rsp_chan)
   );

   a_term_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.end_marker |-> rsp_chan.char_len == 3'd0)
      else $error("terminator beat carries character bytes");

   a_char_len: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.end_marker |->
         rsp_chan.char_len != 3'd0 && rsp_chan.char_len <= MAX_LEN)
      else $error("character beat with bad length");

   a_columns_range: assert property (@(posedge clock) disable iff (reset)
      columns_ff != '0 && columns_ff <= COL_W'(MAX_COLUMNS))
      else $error("column width out of range");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready && state == ST_DECODE)
      else $error("second byte accepted before decode");

endmodule

`default_nettype wire

@@ verif/wrap_output_checker.sv @@
// Checker for the word wrap core: tracks byte beats and column writes, predicts and compares output.
`timescale 1ns / 1ps

module wrap_output_checker
   import uwrap_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   uwrap_req_if                   req_mon,
   uwrap_rsp_if                   rsp_mon,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic              pready,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output int                     mismatches,
   output int                     pending,
   output int                     bytes_seen,
   output int                     glyphs_seen,
   output int                     texts_seen
);

   localparam int WORD_SLOTS = MAX_COLUMNS + 1;
   localparam logic [ADDR_W-1:0] COLUMNS_ADDR = ADDR_W'({ADDR_COLUMNS, 2'b00});

   typedef struct packed {
      logic [7:0] char_byte0;
      logic [7:0] char_byte1;
      logic [7:0] char_byte2;
      logic [7:0] char_byte3;
      logic [2:0] char_len;
      logic       end_marker;
   } glyph_type;

   logic [31:0] word_buf [WORD_SLOTS];
   logic [2:0]  word_len [WORD_SLOTS];
   int          word_fill;
   int          col_pos;
   int          word_limit;
   int          width_cfg;
   bit          breaking;
   bit          in_word;
   glyph_type   expected_glyphs [$];

   function automatic void push_glyph(logic [31:0] bytes, logic [2:0] len, logic term);
      glyph_type g;
      g.char_byte0 = bytes[7:0];
      g.char_byte1 = bytes[15:8];
      g.char_byte2 = bytes[23:16];
      g.char_byte3 = bytes[31:24];
      g.char_len   = len;
      g.end_marker = term;
      expected_glyphs.push_back(g);
   endfunction

   // one character of an over-long word, newline first when the line is full
   function automatic void push_break_char(int i);
      if (col_pos >= word_limit) begin
         push_glyph(32'(CHAR_NL), 3'd1, 1'b0);
         col_pos = 0;
      end
      push_glyph(word_buf[i], word_len[i], 1'b0);
      if (col_pos < MAX_COLUMNS) col_pos++;
   endfunction

   function automatic void close_word();
      if (!in_word) return;
      if (breaking) begin
         push_break_char(0);
      end else begin
         if (col_pos > 0) begin
            if (col_pos + 1 + word_fill <= word_limit) begin
               push_glyph(32'(CHAR_SP), 3'd1, 1'b0);
               col_pos++;
            end else begin
               push_glyph(32'(CHAR_NL), 3'd1, 1'b0);
               col_pos = 0;
            end
         end
         for (int i = 0; i < word_fill; i++) push_glyph(word_buf[i], word_len[i], 1'b0);
         col_pos += word_fill;
         if (col_pos > MAX_COLUMNS) col_pos = MAX_COLUMNS;
      end
      in_word   = 1'b0;
      breaking  = 1'b0;
      word_fill = 0;
   endfunction

   function automatic void wrap_byte(logic [7:0] b, logic last);
      int tail;
      if (b == CHAR_SP) begin
         close_word();
      end else if (in_word && word_fill > 0 && (b & CONT_MASK) == CONT_TAG) begin
         tail = word_fill - 1;
         if (word_len[tail] < MAX_LEN) begin
            word_buf[tail] = word_buf[tail] | (32'(b) << (8 * word_len[tail]));
            word_len[tail] = word_len[tail] + 3'd1;
         end
      end else begin
         if (!in_word) begin
            in_word    = 1'b1;
            breaking   = 1'b0;
            word_fill  = 0;
            word_limit = width_cfg;
         end else if (breaking) begin
            push_break_char(0);
            word_fill = 0;
         end else if (word_fill >= word_limit) begin
            if (col_pos > 0) begin
               push_glyph(32'(CHAR_NL), 3'd1, 1'b0);
               col_pos = 0;
            end
            for (int i = 0; i < word_fill; i++) push_break_char(i);
            breaking  = 1'b1;
            word_fill = 0;
         end
         if (word_fill < WORD_SLOTS) begin
            word_buf[word_fill] = 32'(b);
            word_len[word_fill] = 3'd1;
            word_fill++;
         end
      end
      if (last) begin
         close_word();
         push_glyph(32'd0, 3'd0, 1'b1);
         col_pos = 0;
      end
   endfunction

   always @(posedge clock) begin
      glyph_type got;
      glyph_type want;
      int        field;
      if (reset) begin
         word_fill   = 0;
         col_pos     = 0;
         word_limit  = 0;
         width_cfg   = MAX_COLUMNS;
         breaking    = 1'b0;
         in_word     = 1'b0;
         mismatches  = 0;
         bytes_seen  = 0;
         glyphs_seen = 0;
         texts_seen  = 0;
         expected_glyphs.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == COLUMNS_ADDR) begin
            field = int'(pwdata[5:0]);
            if (field < 1) field = 1;
            if (field > MAX_COLUMNS) field = MAX_COLUMNS;
            width_cfg = field;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.char_byte0, rsp_mon.char_byte1, rsp_mon.char_byte2,
                    rsp_mon.char_byte3, rsp_mon.char_len, rsp_mon.end_marker};
            glyphs_seen++;
            if (expected_glyphs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected character beat %02h %02h %02h %02h len %0d end %0b",
                           $time, got.char_byte0, got.char_byte1, got.char_byte2,
                           got.char_byte3, got.char_len, got.end_marker);
            end else begin
               want = expected_glyphs.pop_front();
               if (got.char_byte0 !== want.char_byte0 || got.char_byte1 !== want.char_byte1 ||
                   got.char_byte2 !== want.char_byte2 || got.char_byte3 !== want.char_byte3 ||
                   got.char_len !== want.char_len || got.end_marker !== want.end_marker) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: character mismatch on beat %0d", $time, glyphs_seen);
                     $display("   expected %02h %02h %02h %02h len %0d end %0b",
                              want.char_byte0, want.char_byte1, want.char_byte2,
                              want.char_byte3, want.char_len, want.end_marker);
                     $display("   actual   %02h %02h %02h %02h len %0d end %0b",
                              got.char_byte0, got.char_byte1, got.char_byte2,
                              got.char_byte3, got.char_len, got.end_marker);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            bytes_seen++;
            if (req_mon.end_of_text) texts_seen++;
            wrap_byte(req_mon.text_byte, req_mon.end_of_text);
         end
      end
      pending = expected_glyphs.size();
   end

endmodule

@@ verif/utf8_greedy_word_wrap_core_tb.sv @@
// Testbench top for the word wrap core: text stimulus, column writes, back-pressure and verdict.
`timescale 1ns / 1ps

module utf8_greedy_word_wrap_core_tb;

   import uwrap_pkg::*;

   localparam int ITEM_TARGET   = 410;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 40;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PLAN_LEN      = 9;
   localparam int WIDTH_PLAN [PLAN_LEN] = '{3, 60, 1, 8, 17, 2, 45, 5, 11};
   localparam logic [ADDR_W-1:0] COLUMNS_ADDR = ADDR_W'({ADDR_COLUMNS, 2'b00});

   logic              clock = 1'b0;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   uwrap_req_if req_chan ();
   uwrap_rsp_if rsp_chan ();

   int         mismatches;
   int         pending;
   int         bytes_seen;
   int         glyphs_seen;
   int         texts_seen;
   int         bytes_sent;
   int         settings_done;
   int         width_now;
   int         calm_left;
   bit         hold_req;
   logic [7:0] text_q [$];

   utf8_greedy_word_wrap_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   wrap_output_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .mismatches (mismatches),
      .pending    (pending),
      .bytes_seen (bytes_seen),
      .glyphs_seen(glyphs_seen),
      .texts_seen (texts_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else begin
         gap = idle_gap();
         if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.text_byte   <= b;
      req_chan.end_of_text <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   // only with no character outstanding and the block settled
   task automatic write_columns(logic [31:0] value);
      int field;
      req_chan.valid <= 1'b0;
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= COLUMNS_ADDR;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      field = int'(value[5:0]);
      width_now = (field < 1) ? 1 : (field > MAX_COLUMNS) ? MAX_COLUMNS : field;
      settings_done++;
   endtask

   task automatic push_char();
      int r;
      int n_cont;
      r = $urandom_range(0, 99);
      n_cont = 0;
      if (r < 60) begin
         text_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end else if (r < 75) begin
         text_q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
         n_cont = 1;
      end else if (r < 85) begin
         text_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
         n_cont = 2;
      end else if (r < 92) begin
         text_q.push_back(8'($urandom_range(8'hF0, 8'hF4)));
         n_cont = 3;
      end else if (r < 96) begin
         text_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
         n_cont = $urandom_range(4, 6);
      end else begin
         text_q.push_back(8'($urandom_range(1, 255)));
      end
      repeat (n_cont) text_q.push_back(8'(CONT_TAG | $urandom_range(0, 63)));
   endtask

   task automatic make_text();
      int n_words;
      int n_chars;
      int r;
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 4)) text_q.push_back(CHAR_SP);
         return;
      end
      n_words = $urandom_range(1, 10);
      if ($urandom_range(0, 7) == 0) text_q.push_back(CHAR_SP);
      for (int w = 0; w < n_words; w++) begin
         r = $urandom_range(0, 99);
         if (r < 60) n_chars = $urandom_range(1, width_now);
         else if (r < 85) n_chars = $urandom_range(1, 3);
         else n_chars = $urandom_range(width_now + 1, width_now + 12);
         // stray continuation byte opening a word
         if ($urandom_range(0, 15) == 0) text_q.push_back(8'(CONT_TAG | $urandom_range(0, 63)));
         repeat (n_chars) push_char();
         if (w < n_words - 1 || $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) text_q.push_back(CHAR_SP);
         if (bytes_sent + text_q.size() >= ITEM_TARGET) break;
      end
   endtask

   initial begin : drain_side
      int gap;
      bit hold_done;
      hold_done = 1'b0;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_req && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(negedge clock);
         gap = idle_gap();
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("No beat on either channel for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int          plan_idx;
      logic [31:0] setting;
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_chan.valid       = 1'b0;
      req_chan.text_byte   = 8'h00;
      req_chan.end_of_text = 1'b0;
      hold_req             = 1'b0;
      bytes_sent           = 0;
      settings_done        = 0;
      calm_left            = 0;
      width_now            = MAX_COLUMNS;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // lone continuation byte, over-long character, space run, zero byte
      text_q = '{8'h80, 8'hC3, 8'hA9, 8'hBF, 8'hBF, 8'hBF, CHAR_SP, CHAR_SP,
                 8'h00, 8'hFF, 8'h7F};
      send_text();
      text_q = '{CHAR_SP, CHAR_SP};
      send_text();
      // zero low bits give width 1
      write_columns(32'h0000_0040);
      text_q = '{8'h61, 8'h62, 8'h63};
      send_text();
      // saturates to full width, then narrowed mid-word
      write_columns(32'hFFFF_FFFF);
      send_byte(8'h78, 1'b0);
      send_byte(8'h79, 1'b0);
      write_columns(32'h0000_0002);
      text_q = '{8'h7A, CHAR_SP, 8'h70, 8'h71, 8'h72};
      send_text();

      plan_idx = 0;
      while (bytes_sent < ITEM_TARGET) begin
         setting = $urandom();
         if (plan_idx % 3 != 2) setting[5:0] = 6'(WIDTH_PLAN[plan_idx % PLAN_LEN]);
         write_columns(setting);
         if (plan_idx == 0) hold_req = 1'b1;
         repeat ($urandom_range(1, 3)) begin
            if (bytes_sent < ITEM_TARGET) begin
               make_text();
               send_text();
            end
         end
         plan_idx++;
      end

      req_chan.valid <= 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run: %0d text bytes in %0d texts over %0d column settings,", bytes_seen,
               texts_seen, settings_done);
      $display("     %0d wrapped character beats compared, %0d mismatches.", glyphs_seen,
               mismatches);
      if (mismatches == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
